[design/gdh_pkg.sv]
// Shared types, widths and codes for the grid distance heuristic core.
`default_nettype none
package gdh_pkg;
    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int WEIGHT_BITS  = 12;
    localparam int WEIGHT_FRAC  = 8;
    localparam int OUT_BITS     = 42;
    localparam int MODE_BITS    = 3;
    localparam int ADDR_BITS    = 3;

    localparam int SUM_BITS     = COORD_BITS + 2;
    localparam int SQT_BITS     = 2 * COORD_BITS;
    localparam int SQ_BITS      = 2 * COORD_BITS + 2;
    localparam int PROD_BITS    = WEIGHT_BITS + COORD_BITS;
    localparam int DIAG_BITS    = PROD_BITS + 1;
    localparam int N_BITS       = SQ_BITS + 2 * FRAC_BITS;
    localparam int ROOT_BITS    = (N_BITS + 1) / 2;
    localparam int NPAD_BITS    = 2 * ROOT_BITS;
    localparam int REM_BITS     = ROOT_BITS + 1;
    localparam int TRY_BITS     = REM_BITS + 2;
    localparam int DIAG_UP      = (FRAC_BITS > WEIGHT_FRAC) ? FRAC_BITS - WEIGHT_FRAC : 0;
    localparam int DIAG_DOWN    = (WEIGHT_FRAC > FRAC_BITS) ? WEIGHT_FRAC - FRAC_BITS : 0;

    localparam int IN_BITS      = 6 * COORD_BITS;
    localparam int IN_TDATA     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA    = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [MODE_BITS-1:0] MODE_SUM  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_MAX  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_MIN  = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_SQ   = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_EUC  = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_DIAG = 3'd5;

    localparam logic [ADDR_BITS-1:0] REG_MODE  = 3'd0;
    localparam logic [ADDR_BITS-1:0] REG_DIMS  = 3'd1;
    localparam logic [ADDR_BITS-1:0] REG_WSTR  = 3'd2;
    localparam logic [ADDR_BITS-1:0] REG_WD2   = 3'd3;
    localparam logic [ADDR_BITS-1:0] REG_WD3   = 3'd4;

    typedef struct packed {
        logic [MODE_BITS-1:0]   mode;
        logic                   three_dims;
        logic [WEIGHT_BITS-1:0] w_straight;
        logic [WEIGHT_BITS-1:0] w_diag2;
        logic [WEIGHT_BITS-1:0] w_diag3;
    } cfg_t;

    typedef struct packed {
        logic                 valid;
        logic                 euclid;
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] root;
        logic [NPAD_BITS-1:0] n;
        logic [OUT_BITS-1:0]  other;
    } cell_t;
endpackage
`default_nettype wire

[design/grid_distance_heuristic_core.sv]
// Top level of the grid distance heuristic core: config, front pipe, root chain, output.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+----------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata: point pair, 6 x 16-bit coordinates
//  m_      | out | m_tvalid/m_tready  | m_tdata: distance, 42 bits, 8 fraction bits
//  cfg_    | in  | cfg_wr_en          | cfg_addr register index, cfg_wdata value
//
// One request accepted per cycle unless the output stalls; 3 front stages + ROOT_BITS (25)
// root cells + 1 output register. The square root is a row of cells, one root bit each.
// The whole pipe advances together whenever the output register is empty or drained, so
// s_tready follows m_tready when a result is held.
// aresetn (synchronous) clears valid bits and restores the config registers.
`default_nettype none
module grid_distance_heuristic_core import gdh_pkg::*; (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // input requests
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // [15:0] first_row, [31:16] first_col, [47:32] first_layer,
    // [63:48] second_row, [79:64] second_col, [95:80] second_layer
    input  wire logic [IN_TDATA-1:0]    s_tdata,
    // results
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // [41:0] distance, [47:42] zero
    output logic [OUT_TDATA-1:0]        m_tdata,
    // configuration writes
    input  wire logic                   cfg_wr_en,
    input  wire logic [ADDR_BITS-1:0]   cfg_addr,
    input  wire logic [WEIGHT_BITS-1:0] cfg_wdata
);
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode       <= MODE_SUM;
            cfg_reg.three_dims <= 1'b0;
            cfg_reg.w_straight <= WEIGHT_BITS'(256);
            cfg_reg.w_diag2    <= WEIGHT_BITS'(362);
            cfg_reg.w_diag3    <= WEIGHT_BITS'(443);
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MODE: cfg_reg.mode       <= cfg_wdata[MODE_BITS-1:0];
                REG_DIMS: cfg_reg.three_dims <= cfg_wdata[0];
                REG_WSTR: cfg_reg.w_straight <= cfg_wdata;
                REG_WD2:  cfg_reg.w_diag2    <= cfg_wdata;
                REG_WD3:  cfg_reg.w_diag3    <= cfg_wdata;
                default:  ;  // unmapped index, dropped
            endcase
        end
    end

    // global advance: everything moves when the output slot frees up
    logic adv;
    logic m_valid_reg;
    logic [OUT_BITS-1:0] m_data_reg;

    assign adv      = !m_valid_reg || m_tready;
    assign s_tready = adv;

    cell_t chain [0:ROOT_BITS];

    gdh_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_valid (s_tvalid),
        .in_data  (s_tdata[IN_BITS-1:0]),
        .cfg      (cfg_reg),
        .out_cell (chain[0])
    );

    genvar gi;
    generate
        for (gi = 0; gi < ROOT_BITS; gi++) begin : g_cell
            gdh_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (adv),
                .in_cell  (chain[gi]),
                .out_cell (chain[gi+1])
            );
        end
    endgenerate

    // Euclidean items take the root, the rest their precomputed value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= chain[ROOT_BITS].valid;
            m_data_reg  <= chain[ROOT_BITS].euclid ? OUT_BITS'(chain[ROOT_BITS].root)
                                                   : chain[ROOT_BITS].other;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TDATA'(m_data_reg);
endmodule
`default_nettype wire

[design/gdh_front.sv]
// Front pipeline: absolute differences, products and per-mode results.
`default_nettype none
module gdh_front import gdh_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [IN_BITS-1:0]    in_data,
    input  wire cfg_t                  cfg,
    output cell_t                      out_cell
);
    function automatic logic [COORD_BITS-1:0] absd(input logic [COORD_BITS-1:0] a,
                                                  input logic [COORD_BITS-1:0] b);
        logic signed [COORD_BITS:0] d;
        logic [COORD_BITS:0] m;
        begin
            d = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
            m = d[COORD_BITS] ? (~d + 1'b1) : d;
            return m[COORD_BITS-1:0];
        end
    endfunction

    // stage 1: differences
    logic                  v1_reg;
    logic [COORD_BITS-1:0] dr_reg, dc_reg, dl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            dr_reg <= absd(in_data[COORD_BITS-1:0], in_data[4*COORD_BITS-1:3*COORD_BITS]);
            dc_reg <= absd(in_data[2*COORD_BITS-1:COORD_BITS],
                           in_data[5*COORD_BITS-1:4*COORD_BITS]);
            dl_reg <= cfg.three_dims ?
                      absd(in_data[3*COORD_BITS-1:2*COORD_BITS],
                           in_data[6*COORD_BITS-1:5*COORD_BITS]) : '0;
        end
    end

    // stage 2: squares, weighted products, sum/min/max
    logic                   v2_reg;
    logic [SQT_BITS-1:0]    sqr_reg, sqc_reg, sql_reg;
    logic [PROD_BITS-1:0]   pw_reg, pd_reg;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [COORD_BITS-1:0]  max_reg, min_reg;
    logic [COORD_BITS-1:0]  lo2, hi2;
    logic [WEIGHT_BITS-1:0] dw;

    always_comb begin
        lo2 = (dr_reg < dc_reg) ? dr_reg : dc_reg;
        hi2 = (dr_reg < dc_reg) ? dc_reg : dr_reg;
        dw  = cfg.three_dims ? cfg.w_diag3 : cfg.w_diag2;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg  <= v1_reg;
            sqr_reg <= dr_reg * dr_reg;
            sqc_reg <= dc_reg * dc_reg;
            sql_reg <= dl_reg * dl_reg;
            pw_reg  <= cfg.w_straight * (hi2 - lo2);
            pd_reg  <= dw * lo2;
            sum_reg <= SUM_BITS'(dr_reg) + SUM_BITS'(dc_reg) + SUM_BITS'(dl_reg);
            max_reg <= (dl_reg > hi2) ? dl_reg : hi2;
            min_reg <= (cfg.three_dims && dl_reg < lo2) ? dl_reg : lo2;
        end
    end

    // stage 3: select result, seed the root chain
    logic [SQ_BITS-1:0]   sq;
    logic [DIAG_BITS-1:0] diag;
    logic [OUT_BITS-1:0]  other;
    cell_t                cell_next;
    cell_t                cell_reg;

    always_comb begin
        sq   = SQ_BITS'(sqr_reg) + SQ_BITS'(sqc_reg) + SQ_BITS'(sql_reg);
        diag = DIAG_BITS'(pw_reg) + DIAG_BITS'(pd_reg);
        unique case (cfg.mode)
            MODE_MAX:  other = OUT_BITS'(max_reg) << FRAC_BITS;
            MODE_MIN:  other = OUT_BITS'(min_reg) << FRAC_BITS;
            MODE_SQ:   other = OUT_BITS'(sq) << FRAC_BITS;
            MODE_DIAG: other = (OUT_BITS'(diag) << DIAG_UP) >> DIAG_DOWN;
            default:   other = OUT_BITS'(sum_reg) << FRAC_BITS;
        endcase
        cell_next.valid  = v2_reg;
        cell_next.euclid = (cfg.mode == MODE_EUC);
        cell_next.rem    = '0;
        cell_next.root   = '0;
        cell_next.n      = NPAD_BITS'(sq) << (2 * FRAC_BITS);
        cell_next.other  = other;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;
endmodule
`default_nettype wire

[design/gdh_cell.sv]
// One square-root cell: resolves one root bit and passes the item on.
`default_nettype none
module gdh_cell import gdh_pkg::*; (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire cell_t in_cell,
    output cell_t      out_cell
);
    logic [TRY_BITS-1:0] shifted, trial;
    cell_t               cell_next;
    cell_t               cell_reg;

    always_comb begin
        shifted   = {in_cell.rem, in_cell.n[NPAD_BITS-1 -: 2]};
        trial     = TRY_BITS'({in_cell.root, 2'b01});
        cell_next = in_cell;
        cell_next.n = in_cell.n << 2;
        if (shifted >= trial) begin
            cell_next.rem  = REM_BITS'(shifted - trial);
            cell_next.root = {in_cell.root[ROOT_BITS-2:0], 1'b1};
        end else begin
            cell_next.rem  = REM_BITS'(shifted);
            cell_next.root = {in_cell.root[ROOT_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign out_cell = cell_reg;
endmodule
`default_nettype wire

[design/gdh_checker.sv]
// Port-level checker for the grid distance heuristic core, bound to the top level.
`default_nettype none
module gdh_checker import gdh_pkg::*; (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [OUT_TDATA-1:0] m_tdata
);
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while pipe is stalled");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[OUT_TDATA-1:OUT_BITS] == '0)
        else $error("result padding not zero");
endmodule

bind grid_distance_heuristic_core gdh_checker u_gdh_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
